// ===== hdl/usb_ep0_control_stage_sequencer_core_assert.svh =====
// Assertion macros for the endpoint-zero control stage sequencer.
// Used by the top level; no other dependencies.
`ifndef USB_EP0_CONTROL_STAGE_SEQUENCER_CORE_ASSERT_SVH
`define USB_EP0_CONTROL_STAGE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequence must hold in the same cycle as the antecedent.
`define USBEP0_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define USBEP0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define USBEP0_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define USBEP0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hdl/usbep0_pkg.sv =====
// Package for the endpoint-zero control stage sequencer: widths, event,
// action and request codes, the one-hot stage type and its output encoding.
// No dependencies.
`default_nettype none

package usbep0_pkg;

  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 16;
  localparam int ACT_W  = 2;
  localparam int LEN_W  = 7;
  localparam int ADDR_W = 7;
  localparam int STG_W  = 3;
  localparam int MPS_W  = 7;

  // Event codes.
  localparam logic [OP_W-1:0] OP_BUS_RESET   = 3'd0;
  localparam logic [OP_W-1:0] OP_SETUP       = 3'd1;
  localparam logic [OP_W-1:0] OP_POLL        = 3'd2;
  localparam logic [OP_W-1:0] OP_IN_COMPLETE = 3'd3;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ADDR = 2'd2;

  // Standard request decoding.
  localparam logic [BYTE_W-1:0] REQ_TYPE_MASK      = 8'h7F;
  localparam logic [BYTE_W-1:0] REQ_SET_ADDRESS    = 8'd5;
  localparam logic [BYTE_W-1:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [BYTE_W-1:0] DESC_DEVICE        = 8'd1;

  // Packet size limits.
  localparam logic [MPS_W-1:0] MPS_MIN   = 7'd8;
  localparam logic [MPS_W-1:0] MPS_MAX   = 7'd64;
  localparam logic [MPS_W-1:0] MPS_RESET = 7'd64;

  // Stage codes as seen on the result port.
  localparam logic [STG_W-1:0] STG_CODE_SETUP      = 3'd0;
  localparam logic [STG_W-1:0] STG_CODE_DATA_IN    = 3'd1;
  localparam logic [STG_W-1:0] STG_CODE_IN_IDLE    = 3'd2;
  localparam logic [STG_W-1:0] STG_CODE_IN_ZERO    = 3'd3;
  localparam logic [STG_W-1:0] STG_CODE_STATUS_OUT = 3'd4;
  localparam logic [STG_W-1:0] STG_CODE_STATUS_IN  = 3'd5;

  typedef enum logic [5:0] {
    STG_SETUP      = 6'b000001,
    STG_DATA_IN    = 6'b000010,
    STG_IN_IDLE    = 6'b000100,
    STG_IN_ZERO    = 6'b001000,
    STG_STATUS_OUT = 6'b010000,
    STG_STATUS_IN  = 6'b100000
  } stage_t;

  function automatic logic [STG_W-1:0] stage_code(input stage_t s);
    logic [STG_W-1:0] c;
    case (s)
      STG_SETUP:      c = STG_CODE_SETUP;
      STG_DATA_IN:    c = STG_CODE_DATA_IN;
      STG_IN_IDLE:    c = STG_CODE_IN_IDLE;
      STG_IN_ZERO:    c = STG_CODE_IN_ZERO;
      STG_STATUS_OUT: c = STG_CODE_STATUS_OUT;
      STG_STATUS_IN:  c = STG_CODE_STATUS_IN;
      default:        c = STG_CODE_SETUP;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/usb_ep0_control_stage_sequencer_core.sv =====
// Endpoint-zero control-transfer stage sequencer, top level.
// Depends on usbep0_pkg and usb_ep0_control_stage_sequencer_core_assert.svh.
//
//   channel | direction | handshake           | carries
//   --------+-----------+---------------------+------------------------------------
//   in_     | into      | in_valid / in_stall | one event with its setup fields
//   out_    | out of    | out_valid/out_stall | action, packet, address, new stage
//   cfg_    | into      | cfg_valid/cfg_ready | max packet size for endpoint zero
//
// One request is taken every clock cycle while the result side keeps up.
// A request is held in the input register and then moves on to the result
// register, from which its result is offered; the stage update is a single
// compare, subtract and add between those two registers.
// Reset (rst_n low, synchronous) empties both registers, sets the setup stage,
// clears the byte counters and restores a packet size of 64.
// A stall on the result side holds the result and then backs up into in_stall.
`default_nettype none

module usb_ep0_control_stage_sequencer_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Event channel.
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [usbep0_pkg::OP_W-1:0]     in_opcode,
  input  wire logic [usbep0_pkg::BYTE_W-1:0]   in_request_type,
  input  wire logic [usbep0_pkg::BYTE_W-1:0]   in_request_code,
  input  wire logic [usbep0_pkg::WORD_W-1:0]   in_request_value,
  input  wire logic [usbep0_pkg::WORD_W-1:0]   in_request_length,
  // Result channel.
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [usbep0_pkg::ACT_W-1:0]         out_action,
  output logic [usbep0_pkg::WORD_W-1:0]        out_packet_offset,
  output logic [usbep0_pkg::LEN_W-1:0]         out_packet_length,
  output logic [usbep0_pkg::ADDR_W-1:0]        out_device_address,
  output logic [usbep0_pkg::STG_W-1:0]         out_stage,
  // Configuration channel.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [usbep0_pkg::MPS_W-1:0]    cfg_data
);

  import usbep0_pkg::*;

  `include "usb_ep0_control_stage_sequencer_core_assert.svh"

  // Input register.
  logic                in_full_r, in_full_nxt;
  logic [OP_W-1:0]     op_r;
  logic [BYTE_W-1:0]   rtype_r;
  logic [BYTE_W-1:0]   rcode_r;
  logic [WORD_W-1:0]   rval_r;
  logic [WORD_W-1:0]   rlen_r;

  // Sequencer state.
  stage_t              stage_r, stage_nxt;
  logic [WORD_W-1:0]   bytes_rem_r, bytes_rem_nxt;
  logic [WORD_W-1:0]   send_off_r, send_off_nxt;
  logic [MPS_W-1:0]    mps_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]    action_r, action_nxt;
  logic [WORD_W-1:0]   offset_r, offset_nxt;
  logic [LEN_W-1:0]    length_r, length_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [STG_W-1:0]    stage_out_r;

  logic                in_accept;
  logic                advance;
  logic [MPS_W-1:0]    eff_mps;
  logic [LEN_W-1:0]    pkt_size;
  logic [WORD_W-1:0]   bytes_after;
  logic                std_device_req;

  // The input register moves on whenever the result register is free or is
  // being emptied in this same cycle, so back-to-back requests flow freely.
  assign advance   = in_full_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_full_r && !advance;
  assign in_accept = in_valid && !in_stall;

  assign in_full_nxt   = in_accept ? 1'b1 : (advance ? 1'b0 : in_full_r);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  // The user must make configuration writes only while the block is idle; the block
  // itself does not enforce this, and the register always takes them.
  assign cfg_ready = 1'b1;

  // Packet size clamped to the range that USB allows for endpoint zero.
  always_comb begin
    if (mps_r < MPS_MIN) begin
      eff_mps = MPS_MIN;
    end else if (mps_r > MPS_MAX) begin
      eff_mps = MPS_MAX;
    end else begin
      eff_mps = mps_r;
    end
  end

  // Size of the next data packet: the smaller of the bytes left and the
  // packet size.
  assign pkt_size    = (bytes_rem_r < WORD_W'(eff_mps)) ? bytes_rem_r[LEN_W-1:0] : eff_mps;
  assign bytes_after = bytes_rem_r - WORD_W'(pkt_size);

  // Only standard requests addressed to the device are handled; the direction
  // bit plays no part.
  assign std_device_req = (rtype_r & REQ_TYPE_MASK) == '0;

  // Event decode and stage update.
  always_comb begin
    stage_nxt     = stage_r;
    bytes_rem_nxt = bytes_rem_r;
    send_off_nxt  = send_off_r;
    action_nxt    = ACT_NONE;
    offset_nxt    = '0;
    length_nxt    = '0;
    addr_nxt      = '0;
    case (op_r)
      OP_BUS_RESET: begin
        // A bus reset drops any transfer in progress and the address.
        stage_nxt     = STG_SETUP;
        bytes_rem_nxt = '0;
        send_off_nxt  = '0;
        action_nxt    = ACT_ADDR;
      end
      OP_SETUP: begin
        if (std_device_req) begin
          if (rcode_r == REQ_GET_DESCRIPTOR && rval_r[WORD_W-1:BYTE_W] == DESC_DEVICE) begin
            bytes_rem_nxt = rlen_r;
            send_off_nxt  = '0;
            stage_nxt     = STG_DATA_IN;
          end else if (rcode_r == REQ_SET_ADDRESS) begin
            stage_nxt  = STG_STATUS_IN;
            action_nxt = ACT_ADDR;
            addr_nxt   = rval_r[ADDR_W-1:0];
          end
        end
      end
      OP_POLL: begin
        if (stage_r == STG_DATA_IN) begin
          // Send one packet. When it empties the run, a full last packet
          // must still be closed by a zero-length packet.
          action_nxt    = ACT_SEND;
          offset_nxt    = send_off_r;
          length_nxt    = pkt_size;
          bytes_rem_nxt = bytes_after;
          send_off_nxt  = send_off_r + WORD_W'(pkt_size);
          if (bytes_after != '0) begin
            stage_nxt = STG_IN_IDLE;
          end else if (pkt_size == eff_mps) begin
            stage_nxt = STG_IN_ZERO;
          end else begin
            stage_nxt = STG_STATUS_OUT;
          end
        end else if (stage_r == STG_STATUS_OUT) begin
          stage_nxt = STG_SETUP;
        end else if (stage_r == STG_STATUS_IN) begin
          // Zero-length status packet that completes a SET_ADDRESS.
          stage_nxt  = STG_SETUP;
          action_nxt = ACT_SEND;
        end
      end
      OP_IN_COMPLETE: begin
        if (bytes_rem_r != '0) begin
          stage_nxt = STG_DATA_IN;
        end else if (stage_r == STG_IN_ZERO) begin
          stage_nxt  = STG_STATUS_OUT;
          action_nxt = ACT_SEND;
          offset_nxt = send_off_r;
        end
      end
      default: begin
        // Undefined events leave everything as it is.
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
      stage_r     <= STG_SETUP;
      bytes_rem_r <= '0;
      send_off_r  <= '0;
      mps_r       <= MPS_RESET;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        stage_r     <= stage_nxt;
        bytes_rem_r <= bytes_rem_nxt;
        send_off_r  <= send_off_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        mps_r <= cfg_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_opcode;
      rtype_r <= in_request_type;
      rcode_r <= in_request_code;
      rval_r  <= in_request_value;
      rlen_r  <= in_request_length;
    end
    if (advance) begin
      action_r    <= action_nxt;
      offset_r    <= offset_nxt;
      length_r    <= length_nxt;
      addr_r      <= addr_nxt;
      stage_out_r <= stage_code(stage_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_action         = action_r;
  assign out_packet_offset  = offset_r;
  assign out_packet_length  = length_r;
  assign out_device_address = addr_r;
  assign out_stage          = stage_out_r;

  // A request that leaves the input register is shown as a result next cycle.
  `USBEP0_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_r, "advance lost a result")

  // The zero-length and status-out stages are only ever reached with no
  // data left to send.
  `USBEP0_ASSERT_SAME(a_no_bytes_after_data, clk, rst_n, (stage_r == STG_IN_ZERO) || (stage_r == STG_STATUS_OUT), bytes_rem_r == '0, "bytes left in a closing stage")

  // An address result never carries packet information.
  `USBEP0_ASSERT_SAME(a_addr_no_packet, clk, rst_n, out_valid_r && (action_r == ACT_ADDR), (length_r == '0) && (offset_r == '0), "address result carries packet fields")

  // A data packet never exceeds the largest endpoint-zero packet.
  `USBEP0_ASSERT_SAME(a_packet_bound, clk, rst_n, out_valid_r && (action_r == ACT_SEND), length_r <= MPS_MAX, "packet longer than allowed")

endmodule

`default_nettype wire
